>>> src/tms_pkg.sv
`default_nettype none

package tms_pkg;

    localparam int DEF_STACK_DEPTH = 32;
    localparam logic signed [31:0] ONE_Q = 32'sd65536;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef enum logic [3:0] {
        OP_IDENT = 4'd0,
        OP_ROTX  = 4'd1,
        OP_ROTY  = 4'd2,
        OP_ROTZ  = 4'd3,
        OP_ROTA  = 4'd4,
        OP_SCALE = 4'd5,
        OP_TRANS = 4'd6,
        OP_PUSH  = 4'd7,
        OP_POP   = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PUSH_OVF  = 2'd1,
        ST_POP_UNF   = 2'd2,
        ST_ZERO_AXIS = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_IDENT, S_POP, S_PUSH, S_CORDIC, S_NORM, S_SQSUM,
        S_SQRT, S_DIV, S_AXMUL, S_BUILD, S_LOAD, S_MAC, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        DC_NONE, DC_LATCH, DC_IDENT, DC_POP, DC_PUSH, DC_CORDIC, DC_NORM, DC_SQSUM,
        DC_SQRT, DC_DIV, DC_AXMUL, DC_BUILD, DC_LOAD, DC_MAC, DC_EMIT
    } t_dcmd;

    typedef struct packed {
        logic [3:0]         op;
        logic [15:0]        angle;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] scale_factor;
    } t_item;

    typedef struct packed {
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        t_status            status;
        logic [5:0]         stack_level;
        logic               last;
    } t_result;

    typedef struct packed {
        t_dcmd      op;
        logic [6:0] cnt;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        t_status    status;
        logic       norm_done;
    } t_stat;

    function automatic logic signed [32:0] atan_q30(input logic [3:0] i);
        logic signed [32:0] v;
        unique case (i)
            4'd0:    v = 33'sh020000000;
            4'd1:    v = 33'sh012E4051E;
            4'd2:    v = 33'sh009FB385B;
            4'd3:    v = 33'sh0051111D4;
            4'd4:    v = 33'sh0028B0D43;
            4'd5:    v = 33'sh00145D7E1;
            4'd6:    v = 33'sh000A2F61E;
            4'd7:    v = 33'sh000517C55;
            4'd8:    v = 33'sh00028BE53;
            4'd9:    v = 33'sh000145F2F;
            4'd10:   v = 33'sh0000A2F98;
            4'd11:   v = 33'sh0000517CC;
            4'd12:   v = 33'sh000028BE6;
            4'd13:   v = 33'sh0000145F3;
            4'd14:   v = 33'sh00000A2FA;
            default: v = 33'sh00000517D;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/tms_ctrl.sv
`default_nettype none

module tms_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  tms_pkg::t_stat     i_st,
    output logic               o_busy,
    output tms_pkg::t_cmd      o_cmd
);

    tms_pkg::t_state r_state, n_state;
    logic [6:0]      r_cnt, n_cnt;
    logic [1:0]      r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tms_pkg::S_IDLE;
            r_cnt   <= '0;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 7'd1;
        n_sel   = r_sel;
        unique case (r_state)
            tms_pkg::S_IDLE: begin
                n_cnt = '0;
                if (i_start) n_state = tms_pkg::S_DECODE;
            end
            tms_pkg::S_DECODE: begin
                n_cnt = '0;
                if (i_st.status != tms_pkg::ST_OK) begin
                    n_state = tms_pkg::S_EMIT;
                end else begin
                    unique case (i_st.op)
                        tms_pkg::OP_IDENT: n_state = tms_pkg::S_IDENT;
                        tms_pkg::OP_ROTX,
                        tms_pkg::OP_ROTY,
                        tms_pkg::OP_ROTZ,
                        tms_pkg::OP_ROTA:  n_state = tms_pkg::S_CORDIC;
                        tms_pkg::OP_SCALE,
                        tms_pkg::OP_TRANS: n_state = tms_pkg::S_BUILD;
                        tms_pkg::OP_PUSH:  n_state = tms_pkg::S_PUSH;
                        tms_pkg::OP_POP:   n_state = tms_pkg::S_POP;
                        default:           n_state = tms_pkg::S_EMIT;
                    endcase
                end
            end
            tms_pkg::S_IDENT, tms_pkg::S_POP: begin
                n_cnt   = '0;
                n_state = tms_pkg::S_EMIT;
            end
            tms_pkg::S_PUSH: begin
                if (r_cnt == 7'd16) begin
                    n_cnt   = '0;
                    n_state = tms_pkg::S_EMIT;
                end
            end
            tms_pkg::S_CORDIC: begin
                if (r_cnt == 7'd15) begin
                    n_cnt   = '0;
                    n_state = (i_st.op == tms_pkg::OP_ROTA) ? tms_pkg::S_NORM
                                                             : tms_pkg::S_BUILD;
                end
            end
            tms_pkg::S_NORM: begin
                n_cnt = '0;
                if (i_st.norm_done) n_state = tms_pkg::S_SQSUM;
            end
            tms_pkg::S_SQSUM: begin
                if (r_cnt == 7'd2) begin
                    n_cnt   = '0;
                    n_state = tms_pkg::S_SQRT;
                end
            end
            tms_pkg::S_SQRT: begin
                if (r_cnt == 7'd31) begin
                    n_cnt   = '0;
                    n_sel   = '0;
                    n_state = tms_pkg::S_DIV;
                end
            end
            tms_pkg::S_DIV: begin
                if (r_cnt == 7'd17) begin
                    n_cnt = '0;
                    if (r_sel == 2'd2) begin
                        n_sel   = '0;
                        n_state = tms_pkg::S_AXMUL;
                    end else begin
                        n_sel = r_sel + 2'd1;
                    end
                end
            end
            tms_pkg::S_AXMUL: begin
                if (r_cnt == 7'd14) begin
                    n_cnt   = '0;
                    n_state = tms_pkg::S_BUILD;
                end
            end
            tms_pkg::S_BUILD: begin
                n_cnt   = '0;
                n_state = tms_pkg::S_LOAD;
            end
            tms_pkg::S_LOAD: begin
                if (r_cnt == 7'd16) begin
                    n_cnt   = '0;
                    n_state = tms_pkg::S_MAC;
                end
            end
            tms_pkg::S_MAC: begin
                if (r_cnt == 7'd64) begin
                    n_cnt   = '0;
                    n_state = tms_pkg::S_EMIT;
                end
            end
            tms_pkg::S_EMIT: begin
                if (r_cnt == 7'd16) begin
                    n_cnt   = '0;
                    n_state = tms_pkg::S_IDLE;
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = tms_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy    = (r_state != tms_pkg::S_IDLE);
        o_cmd.cnt = r_cnt;
        o_cmd.sel = r_sel;
        unique case (r_state)
            tms_pkg::S_IDLE:   o_cmd.op = i_start ? tms_pkg::DC_LATCH : tms_pkg::DC_NONE;
            tms_pkg::S_IDENT:  o_cmd.op = tms_pkg::DC_IDENT;
            tms_pkg::S_POP:    o_cmd.op = tms_pkg::DC_POP;
            tms_pkg::S_PUSH:   o_cmd.op = tms_pkg::DC_PUSH;
            tms_pkg::S_CORDIC: o_cmd.op = tms_pkg::DC_CORDIC;
            tms_pkg::S_NORM:   o_cmd.op = tms_pkg::DC_NORM;
            tms_pkg::S_SQSUM:  o_cmd.op = tms_pkg::DC_SQSUM;
            tms_pkg::S_SQRT:   o_cmd.op = tms_pkg::DC_SQRT;
            tms_pkg::S_DIV:    o_cmd.op = tms_pkg::DC_DIV;
            tms_pkg::S_AXMUL:  o_cmd.op = tms_pkg::DC_AXMUL;
            tms_pkg::S_BUILD:  o_cmd.op = tms_pkg::DC_BUILD;
            tms_pkg::S_LOAD:   o_cmd.op = tms_pkg::DC_LOAD;
            tms_pkg::S_MAC:    o_cmd.op = tms_pkg::DC_MAC;
            tms_pkg::S_EMIT:   o_cmd.op = tms_pkg::DC_EMIT;
            default:           o_cmd.op = tms_pkg::DC_NONE;
        endcase
    end

    a_mac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tms_pkg::S_MAC) |-> (r_cnt <= 7'd64))
        else $error("mac step count out of range");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tms_pkg::S_EMIT && r_cnt == 7'd16) |=> (r_state == tms_pkg::S_IDLE))
        else $error("no return to idle after last element");

    a_status_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tms_pkg::S_DECODE && i_st.status != tms_pkg::ST_OK)
        |=> (r_state == tms_pkg::S_EMIT))
        else $error("flagged op did not go straight to emit");

endmodule

`default_nettype wire

>>> src/tms_dpath.sv
`default_nettype none

module tms_dpath #(
    parameter int STACK_DEPTH = tms_pkg::DEF_STACK_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  tms_pkg::t_item     i_item,
    input  tms_pkg::t_cmd      i_cmd,
    output tms_pkg::t_stat     o_st,
    output logic               o_valid,
    output tms_pkg::t_result   o_result
);

    localparam int LIW       = $clog2(STACK_DEPTH);
    localparam int LW        = $clog2(STACK_DEPTH + 1);
    localparam int AW        = LIW + 4;
    localparam int MEM_DEPTH = STACK_DEPTH * 16;

    // control state
    logic [LW-1:0]      r_level;
    logic [15:0]        r_valid0;
    logic               r_ov;

    // item and working registers
    logic [3:0]         r_op;
    tms_pkg::t_status   r_status;
    logic signed [31:0] r_sf;
    logic signed [33:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic               r_flip;
    logic signed [32:0] r_v [3];
    logic [63:0]        r_sn, r_res, r_bit;
    logic [31:0]        r_rem;
    logic [16:0]        r_q;
    logic signed [18:0] r_u [3];
    logic signed [19:0] r_ax [9];
    logic signed [31:0] r_r [16];
    logic signed [31:0] r_cur [16];
    logic signed [65:0] r_acc;

    // stack memory
    logic [31:0]        r_mem [MEM_DEPTH];
    logic [31:0]        r_mem_q;
    logic               r_rd_ok;
    logic [3:0]         r_rd_idx;

    logic [6:0]         w_cnt;
    logic [LW-1:0]      w_lvm1;
    logic [LIW-1:0]     w_top;
    logic               w_full, w_single;
    logic               w_re, w_we;
    logic [AW-1:0]      w_raddr, w_waddr;
    logic [31:0]        w_wdata;
    logic signed [31:0] w_rdata;
    logic [3:0]         w_midx;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod, w_qm, w_rnd;
    logic signed [31:0] w_sat;

    logic [31:0]        w_th, w_th2;
    logic               w_tflip;
    logic signed [33:0] w_xsh, w_ysh, w_cr;
    logic signed [32:0] w_atan;
    logic signed [17:0] w_c0, w_s0, w_c, w_s;
    logic signed [18:0] w_t;

    logic signed [32:0] w_absf [3];
    logic [31:0]        w_abs [3];
    logic               w_norm_done;

    logic [63:0]        w_sqa;
    logic               w_sqge;

    logic [31:0]        w_len;
    logic [47:0]        w_num;
    logic [17:0]        w_nlo;
    logic [4:0]         w_didx;
    logic [31:0]        w_remin, w_remn;
    logic [32:0]        w_dsh;
    logic               w_dge;
    logic [16:0]        w_qf;
    logic signed [18:0] w_un;
    logic [3:0]         w_axi;

    logic signed [31:0] w_rb [16];

    assign w_cnt    = i_cmd.cnt;
    assign w_lvm1   = r_level - LW'(1);
    assign w_top    = w_lvm1[LIW-1:0];
    assign w_full   = (r_level >= LW'(STACK_DEPTH));
    assign w_single = (r_level <= LW'(1));

    // memory ports
    assign w_re    = (i_cmd.op == tms_pkg::DC_LOAD || i_cmd.op == tms_pkg::DC_PUSH ||
                      i_cmd.op == tms_pkg::DC_EMIT) && (w_cnt < 7'd16);
    assign w_raddr = {w_top, w_cnt[3:0]};
    assign w_midx  = 4'(w_cnt[6:2] - 5'd1);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {w_top, w_midx};
        w_wdata = w_sat;
        if (i_cmd.op == tms_pkg::DC_MAC && w_cnt[1:0] == 2'd0 && w_cnt != 7'd0) begin
            w_we = 1'b1;
        end else if (i_cmd.op == tms_pkg::DC_PUSH && w_cnt != 7'd0) begin
            w_we    = 1'b1;
            w_waddr = {w_top + LIW'(1), 4'(w_cnt - 7'd1)};
            w_wdata = w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_mem_q  <= r_mem[w_raddr];
            r_rd_ok  <= (w_top != '0) || r_valid0[w_cnt[3:0]];
            r_rd_idx <= w_cnt[3:0];
        end
    end

    // level zero entries never written read as identity
    assign w_rdata = r_rd_ok ? r_mem_q :
                     ((r_rd_idx[1:0] == r_rd_idx[3:2]) ? tms_pkg::ONE_Q : 32'sd0);

    // cordic
    assign w_th    = {i_item.angle, 16'h0000};
    assign w_tflip = w_th[31] ^ w_th[30];
    assign w_th2   = {w_th[31] ^ w_tflip, w_th[30:0]};
    assign w_xsh   = r_cx >>> w_cnt[3:0];
    assign w_ysh   = r_cy >>> w_cnt[3:0];
    assign w_atan  = tms_pkg::atan_q30(w_cnt[3:0]);
    assign w_cr    = (r_cx + 34'sd8192) >>> 14;
    assign w_c0    = 18'(w_cr);
    assign w_s0    = 18'((r_cy + 34'sd8192) >>> 14);
    assign w_c     = r_flip ? -w_c0 : w_c0;
    assign w_s     = r_flip ? -w_s0 : w_s0;
    assign w_t     = 19'sd65536 - 19'(w_c);

    // axis normalization
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_absf[k] = r_v[k][32] ? -r_v[k] : r_v[k];
            w_abs[k]  = w_absf[k][31:0];
        end
    end
    assign w_norm_done = (w_absf[0][32:30] != 3'd0) || (w_absf[1][32:30] != 3'd0) ||
                         (w_absf[2][32:30] != 3'd0);

    // integer square root
    assign w_sqa  = r_res + r_bit;
    assign w_sqge = (r_sn >= w_sqa);

    // restoring divide, one quotient bit a step
    assign w_len   = r_res[31:0];
    assign w_num   = {w_abs[i_cmd.sel], 16'h0000} + 48'(w_len >> 1);
    assign w_nlo   = w_num[17:0];
    assign w_didx  = 5'd17 - w_cnt[4:0];
    assign w_remin = (w_cnt == 7'd0) ? {2'b00, w_num[47:18]} : r_rem;
    assign w_dsh   = {w_remin, w_nlo[w_didx]};
    assign w_dge   = (w_dsh >= {1'b0, w_len});
    assign w_remn  = w_dge ? 32'(w_dsh - {1'b0, w_len}) : w_dsh[31:0];
    assign w_qf    = {r_q[15:0], w_dge};
    assign w_un    = r_v[i_cmd.sel][32] ? -signed'({2'b00, w_qf}) : signed'({2'b00, w_qf});

    // shared multiplier
    assign w_axi = (w_cnt[3:0] < 4'd6) ? w_cnt[3:0] : 4'(w_cnt[3:0] - 4'd6);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.op)
            tms_pkg::DC_SQSUM: begin
                w_ma = r_v[w_cnt[1:0]];
                w_mb = r_v[w_cnt[1:0]];
            end
            tms_pkg::DC_AXMUL: begin
                if (w_cnt[3:0] < 4'd6) begin
                    unique case (w_cnt[2:0])
                        3'd0: begin w_ma = 33'(r_u[0]); w_mb = 33'(r_u[0]); end
                        3'd1: begin w_ma = 33'(r_u[1]); w_mb = 33'(r_u[1]); end
                        3'd2: begin w_ma = 33'(r_u[2]); w_mb = 33'(r_u[2]); end
                        3'd3: begin w_ma = 33'(r_u[0]); w_mb = 33'(r_u[1]); end
                        3'd4: begin w_ma = 33'(r_u[0]); w_mb = 33'(r_u[2]); end
                        default: begin w_ma = 33'(r_u[1]); w_mb = 33'(r_u[2]); end
                    endcase
                end else if (w_cnt[3:0] < 4'd12) begin
                    w_ma = 33'(w_t);
                    w_mb = 33'(r_ax[w_axi]);
                end else begin
                    w_ma = 33'(w_s);
                    w_mb = 33'(r_u[2'(w_cnt[3:0] - 4'd12)]);
                end
            end
            tms_pkg::DC_MAC: begin
                w_ma = 33'(r_cur[{w_cnt[1:0], w_cnt[3:2]}]);
                w_mb = 33'(r_r[{w_cnt[5:4], w_cnt[1:0]}]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_qm   = (w_prod + 66'sd32768) >>> 16;
    assign w_rnd  = (r_acc + 66'sd32768) >>> 16;

    always_comb begin
        if (w_rnd > 66'sd2147483647) w_sat = 32'sh7FFFFFFF;
        else if (w_rnd < -66'sd2147483648) w_sat = 32'sh80000000;
        else w_sat = 32'(w_rnd);
    end

    // operand matrix
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            w_rb[k] = (k % 5 == 0) ? tms_pkg::ONE_Q : 32'sd0;
        end
        unique case (r_op)
            tms_pkg::OP_ROTX: begin
                w_rb[5] = 32'(w_c);  w_rb[6] = 32'(w_s);
                w_rb[9] = -32'(w_s); w_rb[10] = 32'(w_c);
            end
            tms_pkg::OP_ROTY: begin
                w_rb[0] = 32'(w_c);  w_rb[2] = -32'(w_s);
                w_rb[8] = 32'(w_s);  w_rb[10] = 32'(w_c);
            end
            tms_pkg::OP_ROTZ: begin
                w_rb[0] = 32'(w_c);  w_rb[1] = 32'(w_s);
                w_rb[4] = -32'(w_s); w_rb[5] = 32'(w_c);
            end
            tms_pkg::OP_ROTA: begin
                w_rb[0]  = 32'(w_c) + 32'(r_ax[0]);
                w_rb[5]  = 32'(w_c) + 32'(r_ax[1]);
                w_rb[10] = 32'(w_c) + 32'(r_ax[2]);
                w_rb[1]  = 32'(r_ax[3]) + 32'(r_ax[8]);
                w_rb[4]  = 32'(r_ax[3]) - 32'(r_ax[8]);
                w_rb[2]  = 32'(r_ax[4]) - 32'(r_ax[7]);
                w_rb[8]  = 32'(r_ax[4]) + 32'(r_ax[7]);
                w_rb[6]  = 32'(r_ax[5]) + 32'(r_ax[6]);
                w_rb[9]  = 32'(r_ax[5]) - 32'(r_ax[6]);
            end
            tms_pkg::OP_SCALE: begin
                w_rb[0] = r_sf; w_rb[5] = r_sf; w_rb[10] = r_sf;
            end
            tms_pkg::OP_TRANS: begin
                w_rb[12] = r_v[0][31:0];
                w_rb[13] = r_v[1][31:0];
                w_rb[14] = r_v[2][31:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= LW'(1);
            r_valid0 <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_ov <= (i_cmd.op == tms_pkg::DC_EMIT) && (w_cnt < 7'd16);
            if (w_we && w_waddr[AW-1:4] == '0) r_valid0[w_waddr[3:0]] <= 1'b1;
            if (i_cmd.op == tms_pkg::DC_IDENT) begin
                r_level  <= LW'(1);
                r_valid0 <= '0;
            end else if (i_cmd.op == tms_pkg::DC_POP) begin
                r_level <= r_level - LW'(1);
            end else if (i_cmd.op == tms_pkg::DC_PUSH && w_cnt == 7'd16) begin
                r_level <= r_level + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            tms_pkg::DC_LATCH: begin
                r_op   <= i_item.op;
                r_sf   <= i_item.scale_factor;
                r_v[0] <= 33'(i_item.vec_x);
                r_v[1] <= 33'(i_item.vec_y);
                r_v[2] <= 33'(i_item.vec_z);
                r_cx   <= tms_pkg::CORDIC_X0;
                r_cy   <= '0;
                r_cz   <= 33'(signed'(w_th2));
                r_flip <= w_tflip;
                r_sn   <= '0;
                if (i_item.op == tms_pkg::OP_PUSH && w_full)
                    r_status <= tms_pkg::ST_PUSH_OVF;
                else if (i_item.op == tms_pkg::OP_POP && w_single)
                    r_status <= tms_pkg::ST_POP_UNF;
                else if (i_item.op == tms_pkg::OP_ROTA && i_item.vec_x == 32'sd0 &&
                         i_item.vec_y == 32'sd0 && i_item.vec_z == 32'sd0)
                    r_status <= tms_pkg::ST_ZERO_AXIS;
                else
                    r_status <= tms_pkg::ST_OK;
            end
            tms_pkg::DC_CORDIC: begin
                if (!r_cz[32]) begin
                    r_cx <= r_cx - w_ysh;
                    r_cy <= r_cy + w_xsh;
                    r_cz <= r_cz - w_atan;
                end else begin
                    r_cx <= r_cx + w_ysh;
                    r_cy <= r_cy - w_xsh;
                    r_cz <= r_cz + w_atan;
                end
            end
            tms_pkg::DC_NORM: begin
                if (!w_norm_done) begin
                    for (int k = 0; k < 3; k++) r_v[k] <= r_v[k] <<< 1;
                end
            end
            tms_pkg::DC_SQSUM: begin
                r_sn  <= r_sn + w_prod[63:0];
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            tms_pkg::DC_SQRT: begin
                if (w_sqge) begin
                    r_sn  <= r_sn - w_sqa;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            tms_pkg::DC_DIV: begin
                r_rem <= w_remn;
                r_q   <= w_qf;
                if (w_cnt == 7'd17) r_u[i_cmd.sel] <= w_un;
            end
            tms_pkg::DC_AXMUL: begin
                r_ax[w_axi] <= 20'(w_qm);
            end
            tms_pkg::DC_BUILD: begin
                for (int k = 0; k < 16; k++) r_r[k] <= w_rb[k];
            end
            tms_pkg::DC_LOAD: begin
                if (w_cnt != 7'd0) r_cur[4'(w_cnt - 7'd1)] <= w_rdata;
            end
            tms_pkg::DC_MAC: begin
                r_acc <= (w_cnt[1:0] == 2'd0) ? w_prod : r_acc + w_prod;
            end
            default: begin
            end
        endcase
    end

    assign o_st.op        = r_op;
    assign o_st.status    = r_status;
    assign o_st.norm_done = w_norm_done;

    assign o_valid                 = r_ov;
    assign o_result.element_index  = r_rd_idx;
    assign o_result.element_value  = w_rdata;
    assign o_result.status         = r_status;
    assign o_result.stack_level    = 6'(r_level);
    assign o_result.last           = (r_rd_idx == 4'd15);

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level != '0) && (r_level <= LW'(STACK_DEPTH)))
        else $error("stack level out of range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_rd_idx == 4'd15) |=> !r_ov)
        else $error("element after the last one");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == tms_pkg::DC_SQRT) |-> (r_bit != '0))
        else $error("square root ran past its last step");

endmodule

`default_nettype wire

>>> src/transform_matrix_stack_unit.sv
`default_nettype none

// Stack of column-major 4x4 Q16.16 transform matrices.
// An item (op, angle, vec_x/y/z, scale_factor) is taken at a clock edge with
// start high and busy low. Every item yields 16 element items, index 0 to 15,
// each on o_result for one cycle with o_valid high; last marks index 15.
// The receiver cannot stall the block, so it must take every element.
// Work from accept to the last element, all set by one sequencer:
//   push: 16-entry copy through the memory's read and write ports
//   scale, translate: 64 multiply-accumulates on one shared multiplier
//   rotate about X, Y or Z: adds 16 CORDIC iterations
//   rotate about an axis: adds a normalizing shift, 32-step square root,
//   three 18-step divides and 15 products
// The next item is accepted in the cycle after its last element.
// Reset leaves one level holding identity; the rest of the stack memory is
// undefined until written.

module transform_matrix_stack_unit #(
    parameter int STACK_DEPTH = tms_pkg::DEF_STACK_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  tms_pkg::t_item     i_item,
    output logic               o_valid,
    output tms_pkg::t_result   o_result
);

    tms_pkg::t_cmd  w_cmd;
    tms_pkg::t_stat w_st;

    tms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (w_st),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    tms_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_st     (w_st),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;

    localparam int N_ITEMS   = 460;
    localparam int CALM_FROM = 420;
    localparam int LEVELS    = tms_pkg::DEF_STACK_DEPTH;
    localparam int LIMIT     = 1_000_000;
    localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

    typedef struct {
        tms_pkg::t_item item;
        int             gap;
    } t_slot;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    tms_pkg::t_item   i_item = '0;
    logic             busy;
    logic             o_valid;
    tms_pkg::t_result o_result;

    t_slot            pending_items[$];
    tms_pkg::t_result expected_elems[$];

    logic signed [31:0] stack_mem [LEVELS][16];
    int      depth_now;
    longint  xf [16];
    int      gap_left;
    int      cycles = 0;
    int      mismatches = 0;
    int      elems_seen = 0;
    int      items_done = 0;
    int      op_seen [16] = '{default: 0};
    int      flagged [4] = '{default: 0};

    const longint atan_q30_tab [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    transform_matrix_stack_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] th;
        bit          flip;
        longint      z, x, y, nx;
        th = {ang, 16'h0000};
        flip = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
        if (flip) th = th + 32'h8000_0000;
        z = longint'($signed(th));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_q30_tab[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_q30_tab[i];
            end
            x = nx;
        end
        c = (x + 8192) >>> 14;
        s = (y + 8192) >>> 14;
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void load_identity();
        for (int k = 0; k < 16; k++) xf[k] = 0;
        xf[0] = 65536;
        xf[5] = 65536;
        xf[10] = 65536;
        xf[15] = 65536;
    endfunction

    function automatic bit build_axis_rot(input longint ax, input longint ay, input longint az,
                                          input longint c, input longint s);
        longint          v [3];
        longint          u [3];
        longint          m, t, q;
        longint unsigned len2, len, a;
        int              sh;
        v[0] = ax;
        v[1] = ay;
        v[2] = az;
        m = 0;
        for (int k = 0; k < 3; k++) begin
            a = (v[k] < 0) ? -v[k] : v[k];
            if (longint'(a) > m) m = a;
        end
        if (m == 0) return 1'b0;
        sh = 0;
        while ((m << sh) < (64'sd1 << 30)) sh++;
        len2 = 0;
        for (int k = 0; k < 3; k++) begin
            v[k] = v[k] * (64'sd1 << sh);
            len2 = len2 + longint'(v[k] * v[k]);
        end
        len = root_floor(len2);
        for (int k = 0; k < 3; k++) begin
            a = ((v[k] < 0) ? -v[k] : v[k]) * 65536;
            q = (a + len / 2) / len;
            u[k] = (v[k] < 0) ? -q : q;
        end
        t = 65536 - c;
        load_identity();
        xf[0]  = c + qmul(t, qmul(u[0], u[0]));
        xf[5]  = c + qmul(t, qmul(u[1], u[1]));
        xf[10] = c + qmul(t, qmul(u[2], u[2]));
        xf[1]  = qmul(t, qmul(u[0], u[1])) + qmul(s, u[2]);
        xf[4]  = qmul(t, qmul(u[0], u[1])) - qmul(s, u[2]);
        xf[2]  = qmul(t, qmul(u[0], u[2])) - qmul(s, u[1]);
        xf[8]  = qmul(t, qmul(u[0], u[2])) + qmul(s, u[1]);
        xf[6]  = qmul(t, qmul(u[1], u[2])) + qmul(s, u[0]);
        xf[9]  = qmul(t, qmul(u[1], u[2])) - qmul(s, u[0]);
        return 1'b1;
    endfunction

    function automatic void post_multiply();
        logic signed [31:0] prod [16];
        longint             hi, lo, p, sum;
        int                 top;
        top = depth_now - 1;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                hi = 0;
                lo = 0;
                for (int k = 0; k < 4; k++) begin
                    p = longint'(stack_mem[top][i + 4 * k]) * xf[k + 4 * j];
                    hi = hi + (p >>> 16);
                    lo = lo + (p & 64'hFFFF);
                end
                sum = hi + ((lo + 32768) >>> 16);
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                prod[i + 4 * j] = sum[31:0];
            end
        end
        for (int k = 0; k < 16; k++) stack_mem[top][k] = prod[k];
    endfunction

    function automatic void predict_matrix(input tms_pkg::t_item it);
        longint           c, s;
        tms_pkg::t_status st;
        tms_pkg::t_result r;
        st = tms_pkg::ST_OK;
        sin_cos(it.angle, c, s);
        load_identity();
        case (it.op)
            tms_pkg::OP_IDENT: begin
                depth_now = 1;
                for (int k = 0; k < 16; k++) stack_mem[0][k] = 32'(xf[k]);
            end
            tms_pkg::OP_ROTX: begin
                xf[5] = c; xf[6] = s; xf[9] = -s; xf[10] = c;
                post_multiply();
            end
            tms_pkg::OP_ROTY: begin
                xf[0] = c; xf[2] = -s; xf[8] = s; xf[10] = c;
                post_multiply();
            end
            tms_pkg::OP_ROTZ: begin
                xf[0] = c; xf[1] = s; xf[4] = -s; xf[5] = c;
                post_multiply();
            end
            tms_pkg::OP_ROTA: begin
                if (build_axis_rot(longint'(it.vec_x), longint'(it.vec_y),
                                   longint'(it.vec_z), c, s))
                    post_multiply();
                else
                    st = tms_pkg::ST_ZERO_AXIS;
            end
            tms_pkg::OP_SCALE: begin
                xf[0]  = longint'(it.scale_factor);
                xf[5]  = longint'(it.scale_factor);
                xf[10] = longint'(it.scale_factor);
                post_multiply();
            end
            tms_pkg::OP_TRANS: begin
                xf[12] = longint'(it.vec_x);
                xf[13] = longint'(it.vec_y);
                xf[14] = longint'(it.vec_z);
                post_multiply();
            end
            tms_pkg::OP_PUSH: begin
                if (depth_now >= LEVELS) begin
                    st = tms_pkg::ST_PUSH_OVF;
                end else begin
                    stack_mem[depth_now] = stack_mem[depth_now - 1];
                    depth_now++;
                end
            end
            tms_pkg::OP_POP: begin
                if (depth_now <= 1) st = tms_pkg::ST_POP_UNF;
                else depth_now--;
            end
            default: ;
        endcase
        op_seen[it.op]++;
        flagged[st]++;
        for (int k = 0; k < 16; k++) begin
            r.element_index = 4'(k);
            r.element_value = stack_mem[depth_now - 1][k];
            r.status        = st;
            r.stack_level   = depth_now[5:0];
            r.last          = (k == 15);
            expected_elems.push_back(r);
        end
    endfunction

    function automatic logic signed [31:0] near_val();
        return $signed($urandom_range(0, 524288)) - 32'sd262144;
    endfunction

    function automatic void add_item(input logic [3:0] op, input logic [15:0] ang,
                                     input logic signed [31:0] vx, input logic signed [31:0] vy,
                                     input logic signed [31:0] vz, input logic signed [31:0] sf);
        t_slot e;
        e.item.op = op;
        e.item.angle = ang;
        e.item.vec_x = vx;
        e.item.vec_y = vy;
        e.item.vec_z = vz;
        e.item.scale_factor = sf;
        e.gap = 0;
        if (pending_items.size() < CALM_FROM && $urandom_range(0, 3) == 0)
            e.gap = $urandom_range(1, 12);
        pending_items.push_back(e);
    endfunction

    function automatic void add_random_item();
        int                 pick;
        logic [3:0]         op;
        logic signed [31:0] vx, vy, vz, sf;
        bit                 wide;
        pick = $urandom_range(0, 99);
        wide = ($urandom_range(0, 9) == 0);
        vx = wide ? $urandom : near_val();
        vy = wide ? $urandom : near_val();
        vz = wide ? $urandom : near_val();
        sf = wide ? $urandom : ($signed($urandom_range(32768, 131072))
                                * ($urandom_range(0, 1) ? 1 : -1));
        if (pick < 8)       op = tms_pkg::OP_IDENT;
        else if (pick < 20) op = tms_pkg::OP_ROTX;
        else if (pick < 32) op = tms_pkg::OP_ROTY;
        else if (pick < 44) op = tms_pkg::OP_ROTZ;
        else if (pick < 58) op = tms_pkg::OP_ROTA;
        else if (pick < 66) op = tms_pkg::OP_SCALE;
        else if (pick < 76) op = tms_pkg::OP_TRANS;
        else if (pick < 86) op = tms_pkg::OP_PUSH;
        else if (pick < 96) op = tms_pkg::OP_POP;
        else                op = 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        if (op == tms_pkg::OP_ROTA && $urandom_range(0, 19) == 0) begin
            vx = 0; vy = 0; vz = 0;
        end
        add_item(op, 16'($urandom), vx, vy, vz, sf);
    endfunction

    // stimulus
    initial begin
        add_item(tms_pkg::OP_ROTX, 16'h0000, 0, 0, 0, 0);
        add_item(tms_pkg::OP_ROTY, 16'h4000, 0, 0, 0, 0);
        add_item(tms_pkg::OP_ROTZ, 16'h8000, 0, 0, 0, 0);
        add_item(tms_pkg::OP_ROTX, 16'hFFFF, 0, 0, 0, 0);
        add_item(tms_pkg::OP_ROTA, 16'h2000, 32'sd65536, 0, 0, 0);
        add_item(tms_pkg::OP_ROTA, 16'hC000, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd1, 0);
        add_item(tms_pkg::OP_ROTA, 16'h1234, 0, 0, 0, 0);
        add_item(tms_pkg::OP_POP, 0, 0, 0, 0, 0);
        add_item(tms_pkg::OP_PUSH, 0, 0, 0, 0, 0);
        add_item(tms_pkg::OP_SCALE, 0, 0, 0, 0, 32'h7FFF_FFFF);
        add_item(tms_pkg::OP_SCALE, 0, 0, 0, 0, 32'h8000_0000);
        add_item(tms_pkg::OP_TRANS, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        add_item(tms_pkg::OP_POP, 0, 0, 0, 0, 0);
        add_item(OP_UNKNOWN_LO, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        add_item(OP_UNKNOWN_HI, 0, 0, 0, 0, 0);
        add_item(tms_pkg::OP_TRANS, 0, 32'sd65536, -32'sd131072, 32'sd3, 0);
        add_item(tms_pkg::OP_IDENT, 0, 0, 0, 0, 0);
        while (pending_items.size() < N_ITEMS) begin
            if ($urandom_range(0, 49) == 0) begin
                // push the stack toward overflow, then pop it down to underflow
                for (int k = 0; k < LEVELS; k++) begin
                    add_item(tms_pkg::OP_PUSH, 0, 0, 0, 0, 0);
                    if ($urandom_range(0, 3) == 0) add_random_item();
                end
                for (int k = 0; k < LEVELS + 1; k++) add_item(tms_pkg::OP_POP, 0, 0, 0, 0, 0);
            end else begin
                add_random_item();
            end
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_items.size() != 0 || start || expected_elems.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d items, %0d elements; ident %0d rot %0d/%0d/%0d axis %0d",
                 items_done, elems_seen, op_seen[tms_pkg::OP_IDENT], op_seen[tms_pkg::OP_ROTX],
                 op_seen[tms_pkg::OP_ROTY], op_seen[tms_pkg::OP_ROTZ],
                 op_seen[tms_pkg::OP_ROTA]);
        $display("scale %0d trans %0d push %0d pop %0d; overflow %0d underflow %0d zero axis %0d",
                 op_seen[tms_pkg::OP_SCALE], op_seen[tms_pkg::OP_TRANS],
                 op_seen[tms_pkg::OP_PUSH], op_seen[tms_pkg::OP_POP],
                 flagged[tms_pkg::ST_PUSH_OVF], flagged[tms_pkg::ST_POP_UNF],
                 flagged[tms_pkg::ST_ZERO_AXIS]);
        if (mismatches == 0 && expected_elems.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        t_slot nxt;
        bit    taken;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
            depth_now = 1;
            for (int k = 0; k < 16; k++) stack_mem[0][k] = (k % 5 == 0) ? 32'sd65536 : 32'sd0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                predict_matrix(i_item);
                items_done++;
            end
            if (start && !taken) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                i_item <= nxt.item;
                gap_left <= nxt.gap;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        tms_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            elems_seen++;
            if (expected_elems.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected element %p", o_result);
            end else begin
                want = expected_elems.pop_front();
                if (o_result.element_index !== want.element_index
                    || o_result.element_value !== want.element_value
                    || o_result.status !== want.status
                    || o_result.stack_level !== want.stack_level
                    || o_result.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_result);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire

>>> sim.f
src/tms_pkg.sv
src/tms_ctrl.sv
src/tms_dpath.sv
src/transform_matrix_stack_unit.sv
bench/tb.sv
